// ----- design/assert_macros.svh -----
// Assertion helpers for the range map. The clock and reset are taken by name
// from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BSRM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define BSRM_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BSRM_ASSERT(label, prop)
`define BSRM_NEVER(label, cond)
`endif

`endif

// ----- design/bsrm_pkg.sv -----
package bsrm_pkg;

  localparam int STORES     = 16;
  localparam int PROCS      = 64;
  localparam int STORE_W    = 4;
  localparam int PID_W      = 6;
  localparam int ADDR_W     = STORE_W + PID_W;
  localparam int DEPTH      = STORES * PROCS;
  localparam int PAGE_W     = 20;
  localparam int CNT_W      = 8;
  localparam int OFS_W      = 7;
  localparam int VADDR_W    = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int OP_W       = 3;

  localparam logic [CNT_W-1:0]   MAX_PAGES  = CNT_W'(128);
  localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(DEPTH - 1);
  localparam logic [PID_W-1:0]   LAST_PID   = PID_W'(PROCS - 1);
  localparam logic [STORE_W-1:0] LAST_STORE = STORE_W'(STORES - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_MAP    = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_UNMAP  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // One per-process entry of a store.
  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  count;
    logic [PAGE_W-1:0] base;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- design/bsrm_ram.sv -----
module bsrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/bsrm_range_chk.sv -----
module bsrm_range_chk (
  input  bsrm_pkg::entry_t                entry,
  input  logic [bsrm_pkg::PAGE_W-1:0]     page,
  output logic                            hit,
  output logic [bsrm_pkg::OFS_W-1:0]      offset
);

  import bsrm_pkg::*;

  logic [PAGE_W:0]   range_end;
  logic [PAGE_W-1:0] diff;

  // The end of the range is one bit wider so that it never wraps.
  assign range_end = {1'b0, entry.base} + {{(PAGE_W + 1 - CNT_W){1'b0}}, entry.count};
  assign diff      = page - entry.base;
  assign hit       = entry.valid && (page >= entry.base) && ({1'b0, page} < range_end);
  assign offset    = diff[OFS_W-1:0];

endmodule

// ----- design/backing_store_range_map_core.sv -----
// Backing store range map.
// Requests arrive on the req channel (req_valid / req_stall) carrying an
// operation, a process, an address or page, a store and a page count. Each
// request gives exactly one response on the rsp channel (rsp_valid /
// rsp_stall) with a status, a store number and a page offset.
// One request is worked on at a time; req_stall stays high until the
// response has been loaded into the output register. Work per request:
//   allocate, map, bad operation: straight to the response
//   lookup: one table read per store visited, at most every store
//   free: one entry write per process
//   unmap: the lookup search, then on a hit one write per process to clear the store
// The per-process table is one RAM with a single write and a single
// registered read port. After reset the table is cleared one entry per cycle,
// while req_stall is high. A response that the receiver stalls holds in the
// output register; the next request is taken meanwhile and waits for it to
// drain.
`include "assert_macros.svh"

module backing_store_range_map_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [bsrm_pkg::OP_W-1:0]      operation,
  input  logic [bsrm_pkg::PID_W-1:0]     proc_id,
  input  logic [bsrm_pkg::VADDR_W-1:0]   virt_addr,
  input  logic [bsrm_pkg::PAGE_W-1:0]    page_number,
  input  logic [bsrm_pkg::STORE_W-1:0]   store_index,
  input  logic [bsrm_pkg::CNT_W-1:0]     page_count,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic                           status,
  output logic [bsrm_pkg::STORE_W-1:0]   store_out,
  output logic [bsrm_pkg::OFS_W-1:0]     page_offset
);

  import bsrm_pkg::*;

  state_t state;
  state_t state_next;

  logic [STORES-1:0]  store_in_use;
  logic [STORES-1:0]  store_referenced;
  logic [ADDR_W-1:0]  sweep_addr;
  logic [STORE_W-1:0] scan_store;
  logic [OP_W-1:0]    op_q;
  logic [PID_W-1:0]   pid_q;
  logic [PAGE_W-1:0]  page_q;
  logic               res_status;
  logic [STORE_W-1:0] res_store;
  logic [OFS_W-1:0]   res_offset;

  logic               accept;
  logic               out_free;
  logic               count_ok;
  logic [STORES-1:0]  free_onehot;
  logic               alloc_ok;
  logic [STORE_W-1:0] alloc_idx;

  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  entry_t             ram_wr_data;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  entry_t             rd_entry;
  logic               hit;
  logic [OFS_W-1:0]   hit_offset;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign count_ok = (page_count != '0) && (page_count <= MAX_PAGES);
  assign rd_entry = entry_t'(ram_rd_data);

  // Lowest free store: adding one carries through the low run of ones.
  assign free_onehot = ~store_in_use & (store_in_use + STORES'(1));
  assign alloc_ok    = |free_onehot;

  always_comb begin
    alloc_idx = '0;
    for (int i = 0; i < STORES; i++) begin
      if (free_onehot[i]) begin
        alloc_idx = alloc_idx | STORE_W'(i);
      end
    end
  end

  bsrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  bsrm_range_chk u_range_chk (
    .entry  (rd_entry),
    .page   (page_q),
    .hit    (hit),
    .offset (hit_offset)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sweep_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (operation) inside
            OP_FREE:             state_next = ST_SWEEP;
            OP_LOOKUP, OP_UNMAP: state_next = ST_SCAN_RD;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (hit) begin
          if (op_q == OP_UNMAP && store_in_use[scan_store]) begin
            state_next = ST_SWEEP;
          end else begin
            state_next = ST_DONE;
          end
        end else if (scan_store == LAST_STORE) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SWEEP: begin
        if (sweep_addr[PID_W-1:0] == LAST_PID) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req_stall   = 1'b1;
    ram_wr_en   = 1'b0;
    ram_wr_addr = sweep_addr;
    ram_wr_data = '0;
    ram_rd_addr = {scan_store, pid_q};
    unique case (state)
      ST_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid && operation == OP_MAP && count_ok) begin
          ram_wr_en         = 1'b1;
          ram_wr_addr       = {store_index, proc_id};
          ram_wr_data.valid = 1'b1;
          ram_wr_data.count = page_count;
          ram_wr_data.base  = page_number;
        end
      end
      ST_SWEEP: begin
        ram_wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      sweep_addr       <= '0;
      store_in_use     <= '0;
      store_referenced <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            op_q       <= operation;
            pid_q      <= proc_id;
            page_q     <= (operation == OP_LOOKUP) ?
                          virt_addr[VADDR_W-1:PAGE_SHIFT] : page_number;
            scan_store <= '0;
            res_offset <= '0;
            case (operation)
              OP_ALLOC: begin
                res_status <= !alloc_ok;
                res_store  <= alloc_ok ? alloc_idx : '0;
              end
              OP_FREE: begin
                sweep_addr                    <= {store_index, {PID_W{1'b0}}};
                store_in_use[store_index]     <= 1'b0;
                store_referenced[store_index] <= 1'b0;
                res_status                    <= 1'b0;
                res_store                     <= '0;
              end
              OP_MAP: begin
                if (count_ok) begin
                  store_in_use[store_index]     <= 1'b1;
                  store_referenced[store_index] <= 1'b1;
                end
                res_status <= !count_ok;
                res_store  <= '0;
              end
              default: begin
                res_status <= 1'b1;
                res_store  <= '0;
              end
            endcase
          end
        end
        ST_SCAN_CHK: begin
          if (hit) begin
            if (op_q == OP_LOOKUP) begin
              res_status <= 1'b0;
              res_store  <= scan_store;
              res_offset <= hit_offset;
            end else if (store_in_use[scan_store]) begin
              // Any unmap hit drops the store's reference and frees the whole store.
              sweep_addr                   <= {scan_store, {PID_W{1'b0}}};
              store_in_use[scan_store]     <= 1'b0;
              store_referenced[scan_store] <= 1'b0;
              res_status                   <= 1'b0;
            end
          end else begin
            scan_store <= scan_store + STORE_W'(1);
          end
        end
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
        end
        ST_DONE: begin
          if (out_free) begin
            status      <= res_status;
            store_out   <= res_store;
            page_offset <= res_offset;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `BSRM_ASSERT(a_rsp_from_done, $rose(rsp_valid) |-> $past(state) == ST_DONE)
  `BSRM_NEVER(a_no_write_in_scan, (state == ST_SCAN_RD || state == ST_SCAN_CHK) && ram_wr_en)
  `BSRM_NEVER(a_swept_store_free, state == ST_SWEEP && store_in_use[sweep_addr[ADDR_W-1:PID_W]])

endmodule

// ----- sim/range_map_monitor.sv -----
`timescale 1ns / 100ps

module range_map_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic [bsrm_pkg::OP_W-1:0]     operation,
  input  logic [bsrm_pkg::PID_W-1:0]    proc_id,
  input  logic [bsrm_pkg::VADDR_W-1:0]  virt_addr,
  input  logic [bsrm_pkg::PAGE_W-1:0]   page_number,
  input  logic [bsrm_pkg::STORE_W-1:0]  store_index,
  input  logic [bsrm_pkg::CNT_W-1:0]    page_count,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  logic                          status,
  input  logic [bsrm_pkg::STORE_W-1:0]  store_out,
  input  logic [bsrm_pkg::OFS_W-1:0]    page_offset,
  output int                            mismatches,
  output int                            pending
);

  import bsrm_pkg::*;

  typedef struct packed {
    logic               status;
    logic [STORE_W-1:0] store;
    logic [OFS_W-1:0]   offset;
  } reply_t;

  bit                in_use [STORES];
  bit                referenced [STORES];
  bit                slot_valid [DEPTH];
  logic [PAGE_W-1:0] slot_base [DEPTH];
  logic [CNT_W-1:0]  slot_count [DEPTH];

  reply_t replies_due[$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void release_store(input int s);
    in_use[s] = 1'b0;
    referenced[s] = 1'b0;
    for (int p = 0; p < PROCS; p++) begin
      slot_valid[s * PROCS + p] = 1'b0;
      slot_base[s * PROCS + p] = '0;
      slot_count[s * PROCS + p] = '0;
    end
  endfunction

  // The range end is base plus count taken without wrap, so a range near the
  // top of the page space never covers low pages.
  function automatic bit find_page(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page,
                                   output int hit, output int ofs);
    int e;
    hit = 0;
    ofs = 0;
    for (int s = 0; s < STORES; s++) begin
      e = s * PROCS + int'(pid);
      if (slot_valid[e] && page >= slot_base[e] &&
          int'(page) < int'(slot_base[e]) + int'(slot_count[e])) begin
        hit = s;
        ofs = int'(page) - int'(slot_base[e]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic reply_t predict_reply(input logic [OP_W-1:0] op,
                                           input logic [PID_W-1:0] pid,
                                           input logic [VADDR_W-1:0] vaddr,
                                           input logic [PAGE_W-1:0] page,
                                           input logic [STORE_W-1:0] sidx,
                                           input logic [CNT_W-1:0] cnt);
    reply_t r;
    int hit;
    int ofs;
    int e;
    r = '0;
    r.status = 1'b1;
    case (op)
      OP_ALLOC: begin
        for (int s = 0; s < STORES; s++) begin
          if (!in_use[s]) begin
            r.status = 1'b0;
            r.store = STORE_W'(s);
            break;
          end
        end
      end
      OP_FREE: begin
        release_store(int'(sidx));
        r.status = 1'b0;
      end
      OP_MAP: begin
        if (cnt >= 1 && cnt <= MAX_PAGES) begin
          e = int'(sidx) * PROCS + int'(pid);
          slot_valid[e] = 1'b1;
          slot_base[e] = page;
          slot_count[e] = cnt;
          in_use[sidx] = 1'b1;
          referenced[sidx] = 1'b1;
          r.status = 1'b0;
        end
      end
      OP_LOOKUP: begin
        if (find_page(pid, vaddr[VADDR_W-1:PAGE_SHIFT], hit, ofs)) begin
          r.status = 1'b0;
          r.store = STORE_W'(hit);
          r.offset = OFS_W'(ofs);
        end
      end
      OP_UNMAP: begin
        // The reference drops to zero on every unmap, so the whole store goes.
        if (find_page(pid, page, hit, ofs) && in_use[hit]) begin
          release_store(hit);
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t due;
    if (rst) begin
      for (int s = 0; s < STORES; s++) begin
        release_store(s);
      end
      replies_due.delete();
      mismatches = 0;
    end else begin
      // A response leaving at this edge belongs to an earlier transfer, so
      // it is checked before a request taken at the same edge is predicted.
      if (rsp_valid && !rsp_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          due = replies_due.pop_front();
          if (status !== due.status) begin
            report_mismatch($sformatf("status got %0b want %0b", status, due.status));
          end
          if (store_out !== due.store) begin
            report_mismatch($sformatf("store_out got %0d want %0d", store_out, due.store));
          end
          if (page_offset !== due.offset) begin
            report_mismatch($sformatf("page_offset got %0d want %0d", page_offset,
                                      due.offset));
          end
        end
      end
      if (req_valid && !req_stall) begin
        replies_due.push_back(predict_reply(operation, proc_id, virt_addr, page_number,
                                            store_index, page_count));
      end
    end
    pending <= replies_due.size();
  end

endmodule

// ----- sim/backing_store_range_map_core_tb.sv -----
`timescale 1ns / 100ps

module backing_store_range_map_core_tb;

  import bsrm_pkg::*;

  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam int              RANDOM_ITEMS    = 650;

  typedef struct {
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] base;
    logic [CNT_W-1:0]  cnt;
  } span_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  logic [OP_W-1:0]    operation;
  logic [PID_W-1:0]   proc_id;
  logic [VADDR_W-1:0] virt_addr;
  logic [PAGE_W-1:0]  page_number;
  logic [STORE_W-1:0] store_index;
  logic [CNT_W-1:0]   page_count;
  logic               rsp_valid;
  logic               rsp_stall;
  logic               status;
  logic [STORE_W-1:0] store_out;
  logic [OFS_W-1:0]   page_offset;

  int    mismatches;
  int    pending;
  int    items_sent;
  bit    quiet;
  span_t spans[$];

  backing_store_range_map_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .proc_id     (proc_id),
    .virt_addr   (virt_addr),
    .page_number (page_number),
    .store_index (store_index),
    .page_count  (page_count),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .store_out   (store_out),
    .page_offset (page_offset)
  );

  range_map_monitor i_monitor (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .proc_id     (proc_id),
    .virt_addr   (virt_addr),
    .page_number (page_number),
    .store_index (store_index),
    .page_count  (page_count),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .store_out   (store_out),
    .page_offset (page_offset),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(9, 0);
  endfunction

  // Starts and ends at a falling edge; returns once the transfer is taken.
  task automatic issue(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                       input logic [VADDR_W-1:0] vaddr, input logic [PAGE_W-1:0] page,
                       input logic [STORE_W-1:0] sidx, input logic [CNT_W-1:0] cnt);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    proc_id = pid;
    virt_addr = vaddr;
    page_number = page;
    store_index = sidx;
    page_count = cnt;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    req_valid = 1'b0;
    items_sent++;
  endtask

  function automatic logic [PAGE_W-1:0] pick_base();
    case ($urandom_range(2, 0))
      0: return PAGE_W'($urandom_range(63, 0));
      1: return PAGE_W'(20'hfffff - $urandom_range(127, 0));
      default: return PAGE_W'($urandom);
    endcase
  endfunction

  task automatic map_and_probe();
    span_t sp;
    span_t target;
    logic [PAGE_W-1:0] page;
    sp.pid = ($urandom_range(3, 0) == 0) ? PID_W'($urandom) : PID_W'($urandom_range(7, 0));
    sp.base = pick_base();
    sp.cnt = ($urandom_range(5, 0) == 0) ? MAX_PAGES : CNT_W'($urandom_range(128, 1));
    issue(OP_MAP, sp.pid, $urandom, sp.base, STORE_W'($urandom), sp.cnt);
    spans.push_back(sp);
    if (spans.size() > 32) begin
      void'(spans.pop_front());
    end
    repeat ($urandom_range(3, 1)) begin
      target = ($urandom_range(2, 0) == 0) ? spans[$urandom_range(spans.size() - 1, 0)] : sp;
      // An offset equal to the count probes one page past the range end.
      page = target.base + PAGE_W'($urandom_range(int'(target.cnt), 0));
      if ($urandom_range(7, 0) == 0) begin
        target.pid = PID_W'($urandom);
      end
      issue(OP_LOOKUP, target.pid, {page, 12'($urandom)}, PAGE_W'($urandom),
            STORE_W'($urandom), CNT_W'($urandom));
    end
  endtask

  task automatic unmap_known();
    span_t target;
    if (spans.size() == 0) begin
      issue(OP_UNMAP, PID_W'($urandom), $urandom, PAGE_W'($urandom), STORE_W'($urandom),
            CNT_W'($urandom));
    end else begin
      target = spans[$urandom_range(spans.size() - 1, 0)];
      issue(OP_UNMAP, target.pid, $urandom,
            target.base + PAGE_W'($urandom_range(int'(target.cnt) - 1, 0)),
            STORE_W'($urandom), CNT_W'($urandom));
    end
  endtask

  task automatic fill_then_allocate();
    for (int s = 0; s < STORES; s++) begin
      issue(OP_MAP, PID_W'($urandom), $urandom, pick_base(), STORE_W'(s),
            CNT_W'($urandom_range(128, 1)));
    end
    issue(OP_ALLOC, PID_W'($urandom), $urandom, PAGE_W'($urandom), STORE_W'($urandom),
          CNT_W'($urandom));
  endtask

  // The receiver holds some responses back, each for a random hold from draw_wait.
  initial begin
    int hold;
    rsp_stall = 1'b0;
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        rsp_stall = 1'b1;
        do @(posedge clk); while (!rsp_valid);
        repeat (hold - 1) @(posedge clk);
        @(negedge clk);
        rsp_stall = 1'b0;
      end
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
      @(negedge clk);
    end
  end

  initial begin
    int kind;
    int next_drain;
    rst = 1'b1;
    req_valid = 1'b0;
    operation = '0;
    proc_id = '0;
    virt_addr = '0;
    page_number = '0;
    store_index = '0;
    page_count = '0;
    quiet = 1'b0;
    items_sent = 0;
    next_drain = 100;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    issue(OP_ALLOC, PID_W'($urandom), $urandom, PAGE_W'($urandom), STORE_W'($urandom),
          CNT_W'($urandom));
    issue(OP_LOOKUP, 6'd0, 32'h0, PAGE_W'($urandom), STORE_W'($urandom), CNT_W'($urandom));
    issue(OP_UNMAP, 6'd0, $urandom, 20'h0, STORE_W'($urandom), CNT_W'($urandom));
    issue(OP_MAP, 6'd5, $urandom, 20'h100, 4'd2, 8'd0);
    issue(OP_MAP, 6'd5, $urandom, 20'h100, 4'd2, 8'd129);
    issue(OP_MAP, 6'd5, $urandom, 20'h100, 4'd2, 8'd255);
    issue(OP_MAP, 6'd0, $urandom, 20'h0, 4'd0, 8'd1);
    issue(OP_LOOKUP, 6'd0, 32'h0000_0fff, PAGE_W'($urandom), STORE_W'($urandom),
          CNT_W'($urandom));
    issue(OP_LOOKUP, 6'd0, 32'h0000_1000, PAGE_W'($urandom), STORE_W'($urandom),
          CNT_W'($urandom));
    issue(OP_MAP, LAST_PID, $urandom, 20'hfffff, LAST_STORE, MAX_PAGES);
    issue(OP_LOOKUP, LAST_PID, 32'hffff_ffff, PAGE_W'($urandom), STORE_W'($urandom),
          CNT_W'($urandom));
    issue(OP_MAP, 6'd0, $urandom, 20'h10, 4'd0, MAX_PAGES);
    issue(OP_LOOKUP, 6'd0, 32'h0008_f000, PAGE_W'($urandom), STORE_W'($urandom),
          CNT_W'($urandom));
    issue(OP_LOOKUP, 6'd0, 32'h0, PAGE_W'($urandom), STORE_W'($urandom), CNT_W'($urandom));
    issue(OP_ALLOC, PID_W'($urandom), $urandom, PAGE_W'($urandom), STORE_W'($urandom),
          CNT_W'($urandom));
    issue(OP_UNMAP, 6'd0, $urandom, 20'h50, STORE_W'($urandom), CNT_W'($urandom));
    issue(OP_LOOKUP, 6'd0, 32'h0005_0abc, PAGE_W'($urandom), STORE_W'($urandom),
          CNT_W'($urandom));
    issue(OP_FREE, PID_W'($urandom), $urandom, PAGE_W'($urandom), LAST_STORE,
          CNT_W'($urandom));
    issue(OP_LOOKUP, LAST_PID, 32'hffff_ffff, PAGE_W'($urandom), STORE_W'($urandom),
          CNT_W'($urandom));
    for (int k = 0; k < 3; k++) begin
      issue(OP_FIRST_UNUSED + OP_W'(k), PID_W'($urandom), $urandom, PAGE_W'($urandom),
            STORE_W'($urandom), CNT_W'($urandom));
    end
    issue(OP_FREE, PID_W'($urandom), $urandom, PAGE_W'($urandom), 4'd3, CNT_W'($urandom));
    issue(OP_UNMAP, LAST_PID, $urandom, 20'hfffff, STORE_W'($urandom), CNT_W'($urandom));

    while (items_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(5, 0) == 0);
      if (items_sent >= next_drain) begin
        while (pending != 0) @(negedge clk);
        next_drain += 150;
      end
      kind = $urandom_range(99, 0);
      if (kind < 45) begin
        map_and_probe();
      end else if (kind < 60) begin
        unmap_known();
      end else if (kind < 68) begin
        issue(OP_FREE, PID_W'($urandom), $urandom, PAGE_W'($urandom), STORE_W'($urandom),
              CNT_W'($urandom));
      end else if (kind < 72) begin
        fill_then_allocate();
      end else if (kind < 80) begin
        issue(OP_ALLOC, PID_W'($urandom), $urandom, PAGE_W'($urandom), STORE_W'($urandom),
              CNT_W'($urandom));
      end else begin
        issue(OP_W'($urandom_range(7, 0)), PID_W'($urandom), $urandom, PAGE_W'($urandom),
              STORE_W'($urandom), CNT_W'($urandom));
      end
    end

    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d responses outstanding", pending);
    $display("status: fail");
    $finish;
  end

endmodule
